[hdl/lsp2xy_pkg.sv]
package lsp2xy_pkg;

	localparam int RANGE_W = 20;
	localparam int INDEX_W = 12;
	localparam int ANGLE_W = 16;
	localparam int COORD_W = 21;
	localparam int GAIN_W = 30;
	localparam int MAG_W = RANGE_W + GAIN_W;
	localparam int VEC_W = 54;
	localparam int Z_W = 33;
	localparam int FRAC_W = 30;
	localparam int ROUND_W = VEC_W - FRAC_W;

	localparam int REG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam logic [REG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE_STEP = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE = 2'd2;

	localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'd0;
	localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST = 16'd16;
	localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 20'hFFFFF;

	localparam int STAGE_MIN = 8;
	localparam int STAGE_MAX = 24;

	localparam logic signed [VEC_W-1:0] HALF_LSB = VEC_W'(1) << (FRAC_W - 1);
	localparam logic signed [ROUND_W-1:0] OUT_LIMIT = ROUND_W'(1048575);

	localparam logic [31:0] ATAN_TURN32 [STAGE_MAX] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	localparam logic [GAIN_W-1:0] INV_GAIN_Q30 [STAGE_MAX-STAGE_MIN+1] = '{
		30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978,
		30'd652032900, 30'd652032881, 30'd652032876, 30'd652032875,
		30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
		30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
		30'd652032874
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [Z_W-1:0] z;
		logic [INDEX_W-1:0] idx;
	} vec_t;

endpackage

[hdl/lsp2xy_ifs.sv]
interface lsp2xy_sample_if;
	logic valid;
	logic ready;
	logic [lsp2xy_pkg::RANGE_W-1:0] range_mm;
	logic [lsp2xy_pkg::INDEX_W-1:0] sample_index;
	modport source(output valid, range_mm, sample_index, input ready);
	modport sink(input valid, range_mm, sample_index, output ready);
endinterface

interface lsp2xy_point_if;
	logic valid;
	logic ready;
	logic signed [lsp2xy_pkg::COORD_W-1:0] x_mm;
	logic signed [lsp2xy_pkg::COORD_W-1:0] y_mm;
	logic [lsp2xy_pkg::INDEX_W-1:0] point_index;
	modport source(output valid, x_mm, y_mm, point_index, input ready);
	modport sink(input valid, x_mm, y_mm, point_index, output ready);
endinterface

interface lsp2xy_cfg_if;
	logic valid;
	logic ready;
	logic [lsp2xy_pkg::REG_IDX_W-1:0] index;
	logic [lsp2xy_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/lsp2xy_prep.sv]
module lsp2xy_prep #(
	parameter logic [16:0] SCAN_LIMIT = 17'd4096,
	parameter logic [lsp2xy_pkg::GAIN_W-1:0] GAIN = 30'd652032874
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [lsp2xy_pkg::RANGE_W-1:0] range_mm,
	input  logic [lsp2xy_pkg::INDEX_W-1:0] sample_index,
	input  logic [lsp2xy_pkg::ANGLE_W-1:0] start_angle,
	input  logic [lsp2xy_pkg::ANGLE_W-1:0] angle_step,
	input  logic [lsp2xy_pkg::RANGE_W-1:0] max_range_mm,
	output logic dn_valid,
	input  logic dn_ready,
	output lsp2xy_pkg::vec_t dn_data
);

	logic en1, en2, en3, keep;
	logic valid_s1, valid_s2, valid_s3;
	logic [lsp2xy_pkg::ANGLE_W+lsp2xy_pkg::INDEX_W-1:0] prod;
	logic [lsp2xy_pkg::ANGLE_W-1:0] theta, shifted, z16;
	logic [1:0] quad;
	logic [lsp2xy_pkg::ANGLE_W-1:0] theta_s1;
	logic [lsp2xy_pkg::RANGE_W-1:0] range_s1;
	logic [lsp2xy_pkg::INDEX_W-1:0] idx_s1, idx_s2;
	logic [lsp2xy_pkg::MAG_W-1:0] mag_s2;
	logic [1:0] quad_s2;
	logic signed [lsp2xy_pkg::ANGLE_W-1:0] z_s2;
	logic signed [lsp2xy_pkg::VEC_W-1:0] mag_ext;
	lsp2xy_pkg::vec_t data_s3;

	assign en3 = !valid_s3 || dn_ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_ready = en1;

	assign keep = (range_mm != '0) && (range_mm < max_range_mm)
		&& ({5'd0, sample_index} < SCAN_LIMIT);
	assign prod = angle_step * sample_index;
	assign theta = start_angle + prod[lsp2xy_pkg::ANGLE_W-1:0];

	assign shifted = theta_s1 + 16'd8192;
	assign quad = shifted[15:14];
	assign z16 = theta_s1 - {quad, 14'd0};

	assign mag_ext = {{(lsp2xy_pkg::VEC_W-lsp2xy_pkg::MAG_W){1'b0}}, mag_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid && keep;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			theta_s1 <= theta;
			range_s1 <= range_mm;
			idx_s1 <= sample_index;
		end
		if (en2) begin
			mag_s2 <= range_s1 * GAIN;
			quad_s2 <= quad;
			z_s2 <= z16;
			idx_s2 <= idx_s1;
		end
		if (en3) begin
			data_s3.z <= {z_s2[15], z_s2, 16'd0};
			data_s3.idx <= idx_s2;
			case (quad_s2)
				2'd0: begin
					data_s3.x <= mag_ext;
					data_s3.y <= '0;
				end
				2'd1: begin
					data_s3.x <= '0;
					data_s3.y <= mag_ext;
				end
				2'd2: begin
					data_s3.x <= -mag_ext;
					data_s3.y <= '0;
				end
				default: begin
					data_s3.x <= '0;
					data_s3.y <= -mag_ext;
				end
			endcase
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data = data_s3;

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (range_mm == '0 || range_mm >= max_range_mm)
		|=> !valid_s1)
		else $error("rejected sample entered the pipeline");

	a_theta: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && keep
		|=> valid_s1 && theta_s1 == $past(theta))
		else $error("beam angle not captured");

	a_resid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (z_s2 >= -16'sd8192) && (z_s2 <= 16'sd8191))
		else $error("residual angle outside quadrant");

endmodule

[hdl/lsp2xy_cell.sv]
module lsp2xy_cell #(
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  lsp2xy_pkg::vec_t up_data,
	output logic dn_valid,
	input  logic dn_ready,
	output lsp2xy_pkg::vec_t dn_data
);

	localparam logic signed [lsp2xy_pkg::Z_W-1:0] ATAN =
		{1'b0, lsp2xy_pkg::ATAN_TURN32[STAGE]};

	logic valid_q;
	logic dir;
	logic signed [lsp2xy_pkg::VEC_W-1:0] dx, dy;
	lsp2xy_pkg::vec_t data_q;

	assign up_ready = !valid_q || dn_ready;
	assign dir = !up_data.z[lsp2xy_pkg::Z_W-1];
	assign dx = up_data.y >>> STAGE;
	assign dy = up_data.x >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			data_q.idx <= up_data.idx;
			if (dir) begin
				data_q.x <= up_data.x - dx;
				data_q.y <= up_data.y + dy;
				data_q.z <= up_data.z - ATAN;
			end else begin
				data_q.x <= up_data.x + dx;
				data_q.y <= up_data.y - dy;
				data_q.z <= up_data.z + ATAN;
			end
		end
	end

	assign dn_valid = valid_q;
	assign dn_data = data_q;

endmodule

[hdl/lsp2xy_round.sv]
module lsp2xy_round (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  lsp2xy_pkg::vec_t up_data,
	lsp2xy_point_if.source points
);

	logic valid_q;
	logic signed [lsp2xy_pkg::VEC_W-1:0] xb, yb, xs, ys;
	logic signed [lsp2xy_pkg::COORD_W-1:0] x_q, y_q;
	logic [lsp2xy_pkg::INDEX_W-1:0] idx_q;

	function automatic logic signed [lsp2xy_pkg::COORD_W-1:0] sat(
		input logic signed [lsp2xy_pkg::ROUND_W-1:0] r
	);
		logic signed [lsp2xy_pkg::ROUND_W-1:0] c;
		begin
			c = r;
			if (r > lsp2xy_pkg::OUT_LIMIT) c = lsp2xy_pkg::OUT_LIMIT;
			if (r < -lsp2xy_pkg::OUT_LIMIT) c = -lsp2xy_pkg::OUT_LIMIT;
			return c[lsp2xy_pkg::COORD_W-1:0];
		end
	endfunction

	assign up_ready = !valid_q || points.ready;
	assign xb = up_data.x + lsp2xy_pkg::HALF_LSB;
	assign yb = up_data.y + lsp2xy_pkg::HALF_LSB;
	assign xs = xb >>> lsp2xy_pkg::FRAC_W;
	assign ys = yb >>> lsp2xy_pkg::FRAC_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			x_q <= sat(xs[lsp2xy_pkg::ROUND_W-1:0]);
			y_q <= sat(ys[lsp2xy_pkg::ROUND_W-1:0]);
			idx_q <= up_data.idx;
		end
	end

	assign points.valid = valid_q;
	assign points.x_mm = x_q;
	assign points.y_mm = y_q;
	assign points.point_index = idx_q;

	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> x_q != {1'b1, {(lsp2xy_pkg::COORD_W-1){1'b0}}})
		else $error("x not saturated");

	a_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> y_q != {1'b1, {(lsp2xy_pkg::COORD_W-1){1'b0}}})
		else $error("y not saturated");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && up_ready |=> valid_q && idx_q == $past(up_data.idx))
		else $error("point index lost");

endmodule

[hdl/lidar_scan_polar_to_xy_unit.sv]
// Converts lidar range samples to x/y points at one sample per clock while the point
// output is ready. A sample with zero range, a range at or above max_range_mm, or an index
// at or beyond SCAN_SAMPLES is dropped on entry and yields no point. Kept samples pass three
// setup stages (beam angle, gain scaling and quadrant fold), then one CORDIC cell per
// rotation stage (ROTATION_STAGES, clamped to 8..24), then a rounding and output register.
// Each stage stalls only when its successor is full, so bubbles close up and samples keep
// entering until the stages fill behind a waiting point. Write registers only while idle.
module lidar_scan_polar_to_xy_unit #(
	parameter int SCAN_SAMPLES = 4096,
	parameter int ROTATION_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	lsp2xy_sample_if.sink samples,
	lsp2xy_point_if.source points,
	lsp2xy_cfg_if.sink cfg
);

	localparam int Stages = (ROTATION_STAGES < lsp2xy_pkg::STAGE_MIN) ? lsp2xy_pkg::STAGE_MIN :
		(ROTATION_STAGES > lsp2xy_pkg::STAGE_MAX) ? lsp2xy_pkg::STAGE_MAX : ROTATION_STAGES;
	localparam logic [16:0] ScanLimit = 17'(SCAN_SAMPLES);
	localparam logic [lsp2xy_pkg::GAIN_W-1:0] Gain =
		lsp2xy_pkg::INV_GAIN_Q30[Stages-lsp2xy_pkg::STAGE_MIN];

	logic [lsp2xy_pkg::ANGLE_W-1:0] start_angle_q, angle_step_q;
	logic [lsp2xy_pkg::RANGE_W-1:0] max_range_q;

	logic chain_valid [Stages+1];
	logic chain_ready [Stages+1];
	lsp2xy_pkg::vec_t chain_data [Stages+1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= lsp2xy_pkg::START_ANGLE_RST;
			angle_step_q <= lsp2xy_pkg::ANGLE_STEP_RST;
			max_range_q <= lsp2xy_pkg::MAX_RANGE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				lsp2xy_pkg::REG_START_ANGLE: start_angle_q <= cfg.data[lsp2xy_pkg::ANGLE_W-1:0];
				lsp2xy_pkg::REG_ANGLE_STEP: angle_step_q <= cfg.data[lsp2xy_pkg::ANGLE_W-1:0];
				lsp2xy_pkg::REG_MAX_RANGE: max_range_q <= cfg.data;
				default: ;
			endcase
		end
	end

	lsp2xy_prep #(
		.SCAN_LIMIT(ScanLimit),
		.GAIN(Gain)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.range_mm(samples.range_mm),
		.sample_index(samples.sample_index),
		.start_angle(start_angle_q),
		.angle_step(angle_step_q),
		.max_range_mm(max_range_q),
		.dn_valid(chain_valid[0]),
		.dn_ready(chain_ready[0]),
		.dn_data(chain_data[0])
	);

	for (genvar i = 0; i < Stages; i++) begin : g_cell
		lsp2xy_cell #(
			.STAGE(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(chain_valid[i]),
			.up_ready(chain_ready[i]),
			.up_data(chain_data[i]),
			.dn_valid(chain_valid[i+1]),
			.dn_ready(chain_ready[i+1]),
			.dn_data(chain_data[i+1])
		);
	end

	lsp2xy_round u_round (
		.clk(clk),
		.arst_n(arst_n),
		.up_valid(chain_valid[Stages]),
		.up_ready(chain_ready[Stages]),
		.up_data(chain_data[Stages]),
		.points(points)
	);

endmodule

[tb/tb_top.sv]
module tb_top;

	localparam int SCAN_SAMPLES = 4096;
	localparam int ROTATION_STAGES = 16;
	localparam int STAGE_COUNT = ROTATION_STAGES < lsp2xy_pkg::STAGE_MIN ? lsp2xy_pkg::STAGE_MIN :
		(ROTATION_STAGES > lsp2xy_pkg::STAGE_MAX ? lsp2xy_pkg::STAGE_MAX : ROTATION_STAGES);
	localparam int LATENCY = STAGE_COUNT + 4;
	localparam logic [lsp2xy_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint COORD_MAX = 1048575;

	localparam longint ATAN_Q32 [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};
	localparam longint GAIN_Q30 [17] = '{
		652039507, 652034532, 652033289, 652032978, 652032900, 652032881,
		652032876, 652032875, 652032874, 652032874, 652032874, 652032874,
		652032874, 652032874, 652032874, 652032874, 652032874
	};

	typedef struct {
		logic signed [lsp2xy_pkg::COORD_W-1:0] x;
		logic signed [lsp2xy_pkg::COORD_W-1:0] y;
		logic [lsp2xy_pkg::INDEX_W-1:0] idx;
	} xy_point_t;

	class xy_point_checker_t;
		bit [lsp2xy_pkg::ANGLE_W-1:0] start_angle;
		bit [lsp2xy_pkg::ANGLE_W-1:0] angle_step;
		bit [lsp2xy_pkg::RANGE_W-1:0] max_range;
		xy_point_t points_due[$];
		int errors;

		function new();
			start_angle = lsp2xy_pkg::START_ANGLE_RST;
			angle_step = lsp2xy_pkg::ANGLE_STEP_RST;
			max_range = lsp2xy_pkg::MAX_RANGE_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [lsp2xy_pkg::REG_IDX_W-1:0] idx,
				logic [lsp2xy_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				lsp2xy_pkg::REG_START_ANGLE: start_angle = data[lsp2xy_pkg::ANGLE_W-1:0];
				lsp2xy_pkg::REG_ANGLE_STEP: angle_step = data[lsp2xy_pkg::ANGLE_W-1:0];
				lsp2xy_pkg::REG_MAX_RANGE: max_range = data[lsp2xy_pkg::RANGE_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [lsp2xy_pkg::COORD_W-1:0] round_mm(longint v);
			longint r;
			r = (v + (64'sd1 <<< 29)) >>> 30;
			if (r > COORD_MAX)
				r = COORD_MAX;
			if (r < -COORD_MAX)
				r = -COORD_MAX;
			return lsp2xy_pkg::COORD_W'(r);
		endfunction

		function xy_point_t rotate_to_xy(bit [lsp2xy_pkg::RANGE_W-1:0] range_mm,
				bit [lsp2xy_pkg::INDEX_W-1:0] idx);
			xy_point_t p;
			bit [lsp2xy_pkg::ANGLE_W-1:0] theta;
			bit [1:0] quad;
			longint x, y, z, mag, dx, dy, t;
			theta = start_angle + angle_step * idx;
			quad = 2'((32'(theta) + 32'd8192) >> 14);
			z = longint'(theta) - longint'(quad) * 16384;
			if (z >= 32768)
				z -= 65536;
			z *= 65536;
			mag = longint'(range_mm) * GAIN_Q30[STAGE_COUNT - lsp2xy_pkg::STAGE_MIN];
			case (quad)
				2'd0: begin x = mag; y = 0; end
				2'd1: begin x = 0; y = mag; end
				2'd2: begin x = -mag; y = 0; end
				default: begin x = 0; y = -mag; end
			endcase
			for (int k = 0; k < STAGE_COUNT; k++) begin
				dx = y >>> k;
				dy = x >>> k;
				if (z >= 0) begin
					t = x - dx; y = y + dy; x = t;
					z -= ATAN_Q32[k];
				end else begin
					t = x + dx; y = y - dy; x = t;
					z += ATAN_Q32[k];
				end
			end
			p.x = round_mm(x);
			p.y = round_mm(y);
			p.idx = idx;
			return p;
		endfunction

		function void note_sample(bit [lsp2xy_pkg::RANGE_W-1:0] range_mm,
				bit [lsp2xy_pkg::INDEX_W-1:0] idx);
			xy_point_t p;
			if (range_mm != 0 && range_mm < max_range && int'(idx) < SCAN_SAMPLES) begin
				p = rotate_to_xy(range_mm, idx);
				points_due = {points_due, p};
			end
		endfunction

		function void flag(string what, longint want, longint got);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s expected %0d got %0d", what, want, got);
		endfunction

		function void check_point(logic signed [lsp2xy_pkg::COORD_W-1:0] x,
				logic signed [lsp2xy_pkg::COORD_W-1:0] y,
				logic [lsp2xy_pkg::INDEX_W-1:0] idx);
			xy_point_t p;
			if (points_due.size() == 0) begin
				flag("unexpected point, index", -1, idx);
				return;
			end
			p = points_due.pop_front();
			if (x !== p.x)
				flag("x_mm", p.x, x);
			if (y !== p.y)
				flag("y_mm", p.y, y);
			if (idx !== p.idx)
				flag("point_index", p.idx, idx);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	bit [lsp2xy_pkg::INDEX_W-1:0] scan_pos;
	xy_point_checker_t book = new();

	lsp2xy_sample_if samples_ch();
	lsp2xy_point_if points_ch();
	lsp2xy_cfg_if cfg_ch();

	lidar_scan_polar_to_xy_unit #(
		.SCAN_SAMPLES(SCAN_SAMPLES),
		.ROTATION_STAGES(ROTATION_STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch),
		.points(points_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		points_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				points_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				points_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && points_ch.valid && points_ch.ready)
			book.check_point(points_ch.x_mm, points_ch.y_mm, points_ch.point_index);
	end

	task automatic send_sample(input bit [lsp2xy_pkg::RANGE_W-1:0] range_mm,
			input bit [lsp2xy_pkg::INDEX_W-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.range_mm <= range_mm;
		samples_ch.sample_index <= idx;
		do @(posedge clk); while (!samples_ch.ready);
		book.note_sample(range_mm, idx);
	endtask

	task automatic write_reg(input logic [lsp2xy_pkg::REG_IDX_W-1:0] idx,
			input logic [lsp2xy_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		book.set_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain_points();
		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (book.points_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic bit [lsp2xy_pkg::RANGE_W-1:0] pick_range(
		bit [lsp2xy_pkg::RANGE_W-1:0] lim
	);
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return '0;
		if (roll < 16 || lim <= 1)
			return lsp2xy_pkg::RANGE_W'($urandom);
		if (roll < 24)
			return lsp2xy_pkg::RANGE_W'($urandom_range(20'hFFFFF, lim));
		if (roll < 40)
			return lsp2xy_pkg::RANGE_W'($urandom_range(lim - 1 < 255 ? lim - 1 : 255, 1));
		return lsp2xy_pkg::RANGE_W'($urandom_range(lim - 1, 1));
	endfunction

	function automatic bit [lsp2xy_pkg::INDEX_W-1:0] pick_index();
		if ($urandom_range(99) < 70)
			scan_pos++;
		else
			scan_pos = lsp2xy_pkg::INDEX_W'($urandom);
		return scan_pos;
	endfunction

	task automatic send_random(input int n);
		for (int k = 0; k < n; k++)
			send_sample(pick_range(book.max_range), pick_index());
	endtask

	task automatic run_phase(input logic [lsp2xy_pkg::CFG_DATA_W-1:0] start,
			input logic [lsp2xy_pkg::CFG_DATA_W-1:0] step,
			input logic [lsp2xy_pkg::CFG_DATA_W-1:0] lim,
			input int send_pct, input int stall_pct, input int n);
		drain_points();
		write_reg(lsp2xy_pkg::REG_START_ANGLE, start);
		write_reg(lsp2xy_pkg::REG_ANGLE_STEP, step);
		write_reg(lsp2xy_pkg::REG_MAX_RANGE, lim);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		send_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		scan_pos = '0;
		samples_ch.valid = 1'b0;
		samples_ch.range_mm = '0;
		samples_ch.sample_index = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_sample(20'd1, 12'd0);
		send_sample(20'hFFFFE, 12'd0);
		send_sample(20'hFFFFF, 12'd5);
		send_sample(20'd0, 12'd7);
		send_sample(20'hFFFFE, 12'd4095);
		send_sample(20'd1, 12'd4095);
		send_sample(20'd500000, 12'd511);
		send_sample(20'd500000, 12'd512);
		send_sample(20'd777777, 12'd256);
		send_sample(20'hFFFFE, 12'd1024);
		send_sample(20'hFFFFE, 12'd1536);
		send_sample(20'hFFFFE, 12'd2048);
		send_sample(20'hFFFFE, 12'd2560);
		send_sample(20'hFFFFE, 12'd3072);
		send_sample(20'd123456, 12'd3583);
		send_sample(20'd123456, 12'd3584);
		send_sample(20'h55555, 12'hAAA);
		send_sample(20'hAAAAA, 12'h555);
		send_random(120);

		run_phase(20'd0, 20'd1, 20'hFFFFF, 61, 0, 180);

		drain_points();
		hold_cycles = 400;
		run_phase(20'hFFFFF, 20'hFFFFF, 20'd600000, 0, 0, 80);
		recv_stall_pct = 61;
		send_random(120);

		run_phase(20'($urandom), 20'($urandom), 20'($urandom), 15, 15, 90);
		drain_points();
		send_random(90);

		run_phase(20'hF1000, 20'd3, 20'd0, 0, 0, 30);
		run_phase(20'd100, 20'd7, 20'd2, 15, 15, 40);

		drain_points();
		write_reg(REG_UNUSED, 20'($urandom));
		run_phase(20'd12345, 20'd40961, 20'hFFFFF, 61, 0, 180);

		run_phase(20'd0, 20'd0, 20'($urandom), 15, 15, 140);

		drain_points();
		hold_cycles = 250;
		run_phase(20'($urandom), 20'($urandom), 20'($urandom_range(20'hFFFFF, 20'h80000)),
			0, 61, 150);

		@(negedge clk);
		samples_ch.valid <= 1'b0;
		for (int spin = 0; spin < 200000 && book.points_due.size() != 0; spin++)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		if (book.errors == 0 && book.points_due.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

[lidar_scan_polar_to_xy_unit.f]
hdl/lsp2xy_pkg.sv
hdl/lsp2xy_ifs.sv
hdl/lsp2xy_prep.sv
hdl/lsp2xy_cell.sv
hdl/lsp2xy_round.sv
hdl/lidar_scan_polar_to_xy_unit.sv
tb/tb_top.sv
